FILE: hdl/lirs_pkg.sv
// ============================================================================
// lirs_pkg: shared types and constants of the linear interpolation resampler
// Holds the fixed widths, the clamp bounds of the step register, the register
// map, the controller state type and the command and status bundles.
// ============================================================================
package lirs_pkg;

    localparam int CHANNELS         = 2;
    localparam int FRAME_COUNT_BITS = 32;
    localparam int FRAC_BITS        = 16;
    localparam int POS_W            = FRAME_COUNT_BITS + FRAC_BITS;
    localparam int SAMPLE_W         = 16;
    localparam int RATIO_W          = 21;
    localparam int LIMIT_W          = 20;
    localparam int MAX_RESULTS      = 17;
    localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    localparam logic [RATIO_W-1:0] RATIO_MIN   = RATIO_W'(4096);
    localparam logic [RATIO_W-1:0] RATIO_MAX   = RATIO_W'(1048576);
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);
    localparam logic [LIMIT_W-1:0] ONE_FRAME   = LIMIT_W'(65536);
    localparam logic [LIMIT_W-1:0] TWO_FRAMES  = LIMIT_W'(131072);

    // Register index, taken from address bit 2.
    localparam logic REG_RATIO  = 1'b0;
    localparam logic REG_STEREO = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio_step;
        logic               stereo_mode;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic capture;
        logic mul;
        logic emit;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_dp_status;

endpackage

FILE: hdl/lirs_regs.sv
// ============================================================================
// lirs_regs: configuration registers
// APB-style write and read of the step register and the stereo mode bit.
// ============================================================================
module lirs_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lirs_pkg::ADDR_W-1:0]   paddr,
    input  logic [lirs_pkg::DATA_W-1:0]   pwdata,
    output logic [lirs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output lirs_pkg::t_cfg                o_cfg
);
    import lirs_pkg::*;

    logic [RATIO_W-1:0] r_ratio_step;
    logic               r_stereo_mode;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_step  <= RATIO_RESET;
            r_stereo_mode <= 1'b1;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_RATIO:  r_ratio_step  <= pwdata[RATIO_W-1:0];
                REG_STEREO: r_stereo_mode <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RATIO:  prdata = DATA_W'(r_ratio_step);
            REG_STEREO: prdata = DATA_W'(r_stereo_mode);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.ratio_step  = r_ratio_step;
    assign o_cfg.stereo_mode = r_stereo_mode;

endmodule

FILE: hdl/lirs_ctrl.sv
// ============================================================================
// lirs_ctrl: resampler sequencer
// Accepts a source frame, then runs check, multiply and emit for every
// output word until the interval or the word limit is exhausted, then closes the frame.
// ============================================================================
module lirs_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  lirs_pkg::t_dp_status   i_status,
    output lirs_pkg::t_dp_cmd      o_cmd
);
    import lirs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MUL;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Closing a frame always returns the sequencer to accept the next one.
    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after closing a frame");

endmodule

FILE: hdl/lirs_dp.sv
// ============================================================================
// lirs_dp: resampler datapath
// Stream state, per-frame operands, the blend multiplier and the output
// register, all driven by commands from the sequencer.
// ============================================================================
module lirs_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lirs_pkg::t_cfg                       i_cfg,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_left,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_right,
    input  logic                                 i_end_of_stream,
    input  lirs_pkg::t_dp_cmd                    i_cmd,
    output lirs_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_out_left,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_out_right,
    output logic                                 o_last_of_run,
    output logic                                 o_stream_done
);
    import lirs_pkg::*;

    // Stream state.
    logic [POS_W-1:0]            r_position;
    logic [FRAME_COUNT_BITS-1:0] r_base_frame;   // frames seen minus one
    logic [SAMPLE_W-1:0]         r_prev [2];
    logic                        r_have_prev;

    // Operands of the frame being worked on.
    logic [SAMPLE_W-1:0] r_cur [2];
    logic [SAMPLE_W-1:0] r_s1  [2];
    logic [SAMPLE_W-1:0] r_mag [2];
    logic                r_neg [2];
    logic [RATIO_W-1:0]  r_ratio;
    logic [LIMIT_W-1:0]  r_limit;
    logic                r_eos;
    logic                r_stereo;
    logic [CNT_W-1:0]    r_cnt;

    // Per-output loop registers.
    logic [RATIO_W-1:0]    r_d;
    logic [FRAC_BITS-1:0]  r_frac;
    logic                  r_tail;
    logic                  r_last;
    logic [2*SAMPLE_W-1:0] r_prod [2];

    // Output register.
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out [2];
    logic                r_out_last;
    logic                r_out_done;

    logic                stereo;
    logic [SAMPLE_W-1:0] in_cur   [2];
    logic [SAMPLE_W-1:0] in_s1    [2];
    logic [SAMPLE_W:0]   in_diff  [2];
    logic [SAMPLE_W:0]   in_absd  [2];
    logic [RATIO_W-1:0]  ratio_cl;
    logic [LIMIT_W-1:0]  in_limit;
    logic [POS_W-1:0]    d_full;
    logic [RATIO_W:0]    d_next;
    logic [SAMPLE_W:0]   blend    [2];
    logic [SAMPLE_W-1:0] value    [2];

    assign stereo = (CHANNELS >= 2) && i_cfg.stereo_mode;

    always_comb begin
        in_cur[0] = i_sample_left;
        in_cur[1] = stereo ? i_sample_right : '0;
        for (int c = 0; c < 2; c++) begin
            in_s1[c]   = r_have_prev ? r_prev[c] : in_cur[c];
            in_diff[c] = {in_cur[c][SAMPLE_W-1], in_cur[c]} - {in_s1[c][SAMPLE_W-1], in_s1[c]};
            in_absd[c] = in_diff[c][SAMPLE_W] ? (~in_diff[c] + 1'b1) : in_diff[c];
        end
    end

    always_comb begin
        if (i_cfg.ratio_step < RATIO_MIN) begin
            ratio_cl = RATIO_MIN;
        end else if (i_cfg.ratio_step > RATIO_MAX) begin
            ratio_cl = RATIO_MAX;
        end else begin
            ratio_cl = i_cfg.ratio_step;
        end
    end

    // An end-of-stream frame also covers the tail past the last frame.
    always_comb begin
        if (i_end_of_stream) begin
            in_limit = TWO_FRAMES + LIMIT_W'(ratio_cl >> 1);
        end else if (r_have_prev) begin
            in_limit = ONE_FRAME;
        end else begin
            in_limit = '0;
        end
    end

    // Distance of the next output position from the start of the interval.
    assign d_full = r_position - {r_base_frame, {FRAC_BITS{1'b0}}};
    assign d_next = {1'b0, r_d} + {1'b0, r_ratio};

    assign o_status.hit = (d_full < {{(POS_W-LIMIT_W){1'b0}}, r_limit})
                          && (r_cnt < CNT_W'(MAX_RESULTS));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            if (r_neg[c]) begin
                blend[c] = {1'b0, r_s1[c]} - {1'b0, r_prod[c][2*SAMPLE_W-1:FRAC_BITS]};
            end else begin
                blend[c] = {1'b0, r_s1[c]} + {1'b0, r_prod[c][2*SAMPLE_W-1:FRAC_BITS]};
            end
            value[c] = r_tail ? r_cur[c] : blend[c][SAMPLE_W-1:0];
        end
    end

    // Stream state: reset and end of stream both return it to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_base_frame <= '1;
            r_prev[0]    <= '0;
            r_prev[1]    <= '0;
            r_have_prev  <= 1'b0;
        end else if (i_cmd.emit) begin
            r_position <= r_position + POS_W'(r_ratio);
        end else if (i_cmd.finish) begin
            if (r_eos) begin
                r_position   <= '0;
                r_base_frame <= '1;
                r_prev[0]    <= '0;
                r_prev[1]    <= '0;
                r_have_prev  <= 1'b0;
            end else begin
                r_base_frame <= r_base_frame + 1'b1;
                r_prev[0]    <= r_cur[0];
                r_prev[1]    <= r_cur[1];
                r_have_prev  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int c = 0; c < 2; c++) begin
                r_cur[c] <= in_cur[c];
                r_s1[c]  <= in_s1[c];
                r_mag[c] <= in_absd[c][SAMPLE_W-1:0];
                r_neg[c] <= in_diff[c][SAMPLE_W];
            end
            r_ratio  <= ratio_cl;
            r_limit  <= in_limit;
            r_eos    <= i_end_of_stream;
            r_stereo <= stereo;
        end
        if (i_cmd.capture) begin
            r_d    <= d_full[RATIO_W-1:0];
            r_frac <= d_full[FRAC_BITS-1:0];
            r_tail <= d_full >= POS_W'(ONE_FRAME);
        end
        if (i_cmd.mul) begin
            for (int c = 0; c < 2; c++) begin
                r_prod[c] <= r_mag[c] * r_frac;
            end
            r_last <= (d_next >= (RATIO_W+1)'(r_limit)) || (r_cnt == CNT_W'(MAX_RESULTS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out[0]   <= value[0];
            r_out[1]   <= r_stereo ? value[1] : '0;
            r_out_last <= r_last;
            r_out_done <= r_last && r_eos;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_left    = r_out[0];
    assign o_out_right   = r_out[1];
    assign o_last_of_run = r_out_last;
    assign o_stream_done = r_out_done;

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_status.out_free)
        else $error("output word written over one not yet taken");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("more output words than allowed for one frame");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_done) |-> o_last_of_run)
        else $error("end of stream flagged on a word that does not close its run");

endmodule

FILE: hdl/linear_interp_resampler.sv
// ============================================================================
// linear_interp_resampler: linear interpolation sample rate converter
// Resamples signed 16-bit mono or stereo frames by an unsigned 5.16 step register.
// ============================================================================
// Each source word closes the interval since the previous frame and produces
// every output frame whose position n*ratio_step falls in it, up to 17, as
// the linear blend of the two frames around that position; the end-of-stream
// word also produces the tail and then returns the stream state to its start.
// A source word is accepted, then for every output word it causes (0 to 17)
// the position is checked against the interval end, the blend is formed in
// the per-channel blend multipliers and the output register is written, which
// waits while that register holds a word not yet taken; then the frame is
// closed. This loop through the blend multipliers is what sets the rate. The
// output register lets the last word of a frame wait for its consumer while
// the next source word is accepted. Configuration is written through the
// APB-style port: the step register at address 0 (clamped to 4096..1048576
// when used) and the stereo mode bit at address 4; write them only while the
// block is idle.
// ============================================================================
module linear_interp_resampler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lirs_pkg::ADDR_W-1:0]          paddr,
    input  logic [lirs_pkg::DATA_W-1:0]          pwdata,
    output logic [lirs_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    // Source frames.
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_left,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_right,
    input  logic                                 i_end_of_stream,
    // Resampled frames.
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_out_left,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_out_right,
    output logic                                 o_last_of_run,
    output logic                                 o_stream_done
);
    import lirs_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    // The register block holds the step and the mode; both are sampled
    // into the datapath when a source word is accepted.
    lirs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The sequencer owns the input handshake and steps the datapath.
    lirs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath keeps the stream position, the previous frame and the
    // output register, and drives the output handshake.
    lirs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_sample_left   (i_sample_left),
        .i_sample_right  (i_sample_right),
        .i_end_of_stream (i_end_of_stream),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_left      (o_out_left),
        .o_out_right     (o_out_right),
        .o_last_of_run   (o_last_of_run),
        .o_stream_done   (o_stream_done)
    );

endmodule
